>>> design/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants for the CSV stream tokenizer
// Holds the payload structs, token event codes, tokenizer flags and the
// result bundle passed from the token logic to the output stage.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Characters with a special meaning in CSV text
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Most results one input item can cause
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [2:0] {
    EV_CONTENT = 3'd0,
    EV_FIELD   = 3'd1,
    EV_ROW     = 3'd2,
    EV_UNTERM  = 3'd3,
    EV_DONE    = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_final;
    logic       no_byte;
  } in_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] content;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic carriage_return_seen;
    logic field_is_empty;
    logic row_is_empty;
  } flags_t;

  localparam flags_t FLAGS_RST = '{
    inside_quotes:        1'b0,
    quote_pending:        1'b0,
    carriage_return_seen: 1'b0,
    field_is_empty:       1'b1,
    row_is_empty:         1'b1
  };

  // Results of one item, packed toward entry 0, with their count
  typedef struct packed {
    out_t [MAX_RES-1:0] ent;
    logic [1:0]         cnt;
  } bundle_t;

endpackage

>>> design/cst_token_logic.sv
// ----------------------------------------------------------------------------
// cst_token_logic: per-byte CSV tokenizing step
// Combinational: from the current flags and one input item, produce the next
// flags and the ordered list of tokens that the item causes.
// ----------------------------------------------------------------------------
module cst_token_logic (
  input  cst_pkg::flags_t  flags_i,
  input  cst_pkg::in_t     in_i,
  output cst_pkg::flags_t  flags_o,
  output cst_pkg::bundle_t bundle_o
);

  always_comb begin
    cst_pkg::flags_t                   f;
    cst_pkg::out_t [cst_pkg::MAX_RES-1:0] cand;
    logic [cst_pkg::MAX_RES-1:0]       en;
    logic                              done_b;
    logic [7:0]                        c;
    logic [1:0]                        n;

    f      = flags_i;
    c      = in_i.text_byte;
    done_b = 1'b0;
    en     = '0;
    n      = 2'd0;

    // Candidate tokens: byte token, final flush/error, stream done
    cand[0] = '{event_res: cst_pkg::EV_CONTENT, content: 8'd0,
                last_of_run: !in_i.is_final};
    cand[1] = '{event_res: cst_pkg::EV_ROW, content: 8'd0, last_of_run: 1'b0};
    cand[2] = '{event_res: cst_pkg::EV_DONE, content: 8'd0, last_of_run: 1'b1};

    // Handle the text byte
    if (!in_i.no_byte) begin
      if (f.quote_pending) begin
        f.quote_pending = 1'b0;
        if (c == cst_pkg::CH_QUOTE) begin
          en[0]            = 1'b1;
          cand[0].content  = cst_pkg::CH_QUOTE;
          f.field_is_empty = 1'b0;
          done_b           = 1'b1;
        end else begin
          f.inside_quotes = 1'b0;
        end
      end
      if (!done_b && f.carriage_return_seen) begin
        f.carriage_return_seen = 1'b0;
        if (c == cst_pkg::CH_LF) begin
          done_b = 1'b1;
        end
      end
      if (!done_b) begin
        if (f.inside_quotes) begin
          if (c == cst_pkg::CH_QUOTE) begin
            f.quote_pending = 1'b1;
          end else begin
            en[0]            = 1'b1;
            cand[0].content  = c;
            f.field_is_empty = 1'b0;
          end
        end else if (c == cst_pkg::CH_QUOTE && f.field_is_empty) begin
          f.inside_quotes = 1'b1;
        end else if (c == cst_pkg::CH_COMMA) begin
          en[0]             = 1'b1;
          cand[0].event_res = cst_pkg::EV_FIELD;
          f.field_is_empty  = 1'b1;
          f.row_is_empty    = 1'b0;
        end else if (c == cst_pkg::CH_CR || c == cst_pkg::CH_LF) begin
          en[0]                  = 1'b1;
          cand[0].event_res      = cst_pkg::EV_ROW;
          f.field_is_empty       = 1'b1;
          f.row_is_empty         = 1'b1;
          f.carriage_return_seen = (c == cst_pkg::CH_CR);
        end else begin
          en[0]            = 1'b1;
          cand[0].content  = c;
          f.field_is_empty = 1'b0;
        end
      end
    end

    // Close the stream: error or flush, then done, then back to reset flags
    if (in_i.is_final) begin
      if (f.quote_pending) begin
        f.quote_pending = 1'b0;
        f.inside_quotes = 1'b0;
      end
      if (f.inside_quotes) begin
        en[1]             = 1'b1;
        cand[1].event_res = cst_pkg::EV_UNTERM;
      end else if (!f.field_is_empty || !f.row_is_empty) begin
        en[1] = 1'b1;
      end
      en[2] = 1'b1;
      f     = cst_pkg::FLAGS_RST;
    end

    // Pack enabled tokens toward entry 0
    bundle_o.ent = cand;
    for (int i = 0; i < cst_pkg::MAX_RES; i++) begin
      if (en[i]) begin
        bundle_o.ent[n] = cand[i];
        n               = n + 2'd1;
      end
    end
    bundle_o.cnt = n;
    flags_o      = f;
  end

endmodule

>>> design/csv_stream_tokenizer_unit.sv
// Path: an item's tokens reach out_ through the bundle register and then the
// output register, which drains the bundle one token a cycle while out_ready
// is high. Throughput: one input item per cycle while each item causes at
// most one token and out_ready is high; an item that causes more tokens holds
// the input until the output register has drained its bundle to the last token.
// Reset: rst_n (synchronous, active low) clears the tokenizer flags to their
// start-of-stream values and empties the result bundle and output register.
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_unit: streaming CSV tokenizer, top level
// Tokenizes each accepted byte into a registered result bundle, then
// drains the bundle through an output register one token per transfer.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cst_pkg::out_t out_data
);

  cst_pkg::flags_t                      flags_r;
  cst_pkg::flags_t                      flags_nxt;
  cst_pkg::bundle_t                     bundle_nxt;
  cst_pkg::out_t [cst_pkg::MAX_RES-1:0] ent_r;
  logic [1:0]                           cnt_r;
  logic                                 out_valid_r;
  cst_pkg::out_t                        out_data_r;
  logic                                 load_out;
  logic                                 in_fire;

  cst_token_logic u_token (
    .flags_i  (flags_r),
    .in_i     (in_data),
    .flags_o  (flags_nxt),
    .bundle_o (bundle_nxt)
  );

  // Move the head token into the output register when it is free
  assign load_out = (cnt_r != 2'd0) && (!out_valid_r || out_ready);
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && load_out);
  assign in_fire  = in_valid && in_ready;

  // Advance tokenizer flags on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= cst_pkg::FLAGS_RST;
    end else if (in_fire) begin
      flags_r <= flags_nxt;
    end
  end

  // Load a new bundle or shift the drained token out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= bundle_nxt.cnt;
    end else if (load_out) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ent_r <= bundle_nxt.ent;
    end else if (load_out) begin
      for (int i = 0; i < cst_pkg::MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= ent_r[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_final_resets_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.is_final |=> flags_r == cst_pkg::FLAGS_RST)
    else $error("flags not back to start after final item");

  a_pending_needs_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    flags_r.quote_pending |-> flags_r.inside_quotes)
    else $error("quote pending outside quoted field");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.event_res == cst_pkg::EV_DONE |-> out_data_r.last_of_run)
    else $error("stream done token not marked last");

  a_accept_only_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cnt_r != 2'd0 |-> load_out && cnt_r == 2'd1)
    else $error("bundle overwritten before drained");
`endif

endmodule

>>> verif/tb_csv_stream_tokenizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csv_stream_tokenizer_unit: self-checking bench for the CSV tokenizer
// Streams CSV text into the tokenizer, predicts the token stream with a
// behavioral copy of the quote/CR/field flags, and compares every token
// transfer in order. Directed text covers quoting, line ends and stream
// end cases; random streams of well-formed rows, broken rows and noise
// follow, with random gaps on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
module tb_csv_stream_tokenizer_unit;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  cst_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  cst_pkg::out_t out_data;

  // Predictor flags
  bit qt_open;
  bit qt_hold;
  bit cr_hold;
  bit fld_blank;
  bit row_blank;

  cst_pkg::out_t pending_tokens[$];
  cst_pkg::out_t want;

  bit calm;
  int errors;
  int items_sent;
  int tokens_seen;
  int streams_done;
  int unterm_seen;
  int unsigned cycle_cnt;

  csv_stream_tokenizer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_flags();
    qt_open   = 1'b0;
    qt_hold   = 1'b0;
    cr_hold   = 1'b0;
    fld_blank = 1'b1;
    row_blank = 1'b1;
  endfunction

  function automatic void push_token(cst_pkg::event_t ev, logic [7:0] c);
    cst_pkg::out_t t;
    t.event_res   = ev;
    t.content     = (ev == cst_pkg::EV_CONTENT) ? c : 8'h00;
    t.last_of_run = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  function automatic void predict_tokens(cst_pkg::in_t d);
    int            n0;
    logic [7:0]    c;
    bit            take;
    cst_pkg::out_t t;
    n0   = pending_tokens.size();
    c    = d.text_byte;
    take = !d.no_byte;
    // Resolve a held quote: doubled quote or close of quoting
    if (take && qt_hold) begin
      qt_hold = 1'b0;
      if (c == cst_pkg::CH_QUOTE) begin
        push_token(cst_pkg::EV_CONTENT, cst_pkg::CH_QUOTE);
        fld_blank = 1'b0;
        take = 1'b0;
      end else begin
        qt_open = 1'b0;
      end
    end
    // Swallow LF right after CR
    if (take && cr_hold) begin
      cr_hold = 1'b0;
      if (c == cst_pkg::CH_LF) take = 1'b0;
    end
    if (take && qt_open) begin
      if (c == cst_pkg::CH_QUOTE) begin
        qt_hold = 1'b1;
      end else begin
        push_token(cst_pkg::EV_CONTENT, c);
        fld_blank = 1'b0;
      end
      take = 1'b0;
    end
    // Unquoted text
    if (take) begin
      if (c == cst_pkg::CH_QUOTE && fld_blank) begin
        qt_open = 1'b1;
      end else if (c == cst_pkg::CH_COMMA) begin
        push_token(cst_pkg::EV_FIELD, 8'h00);
        fld_blank = 1'b1;
        row_blank = 1'b0;
      end else if (c == cst_pkg::CH_CR || c == cst_pkg::CH_LF) begin
        push_token(cst_pkg::EV_ROW, 8'h00);
        fld_blank = 1'b1;
        row_blank = 1'b1;
        cr_hold   = (c == cst_pkg::CH_CR);
      end else begin
        push_token(cst_pkg::EV_CONTENT, c);
        fld_blank = 1'b0;
      end
    end
    // End of stream: error or flush, then done
    if (d.is_final) begin
      if (qt_hold) begin
        qt_hold = 1'b0;
        qt_open = 1'b0;
      end
      if (qt_open) push_token(cst_pkg::EV_UNTERM, 8'h00);
      else if (!fld_blank || !row_blank) push_token(cst_pkg::EV_ROW, 8'h00);
      push_token(cst_pkg::EV_DONE, 8'h00);
      clear_flags();
    end
    // Mark the last token of this item
    if (pending_tokens.size() > n0) begin
      t = pending_tokens.pop_back();
      t.last_of_run = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic fin, input logic nb);
    int           gap;
    cst_pkg::in_t d;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    d.text_byte = b;
    d.is_final  = fin;
    d.no_byte   = nb;
    in_data  = d;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_tokens(d);
    if (!(nb && !fin)) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit fin);
    for (int i = 0; i < s.len(); i++) send_item(s[i], fin && (i == s.len() - 1), 1'b0);
  endtask

  // Hold the input until every predicted token has been seen
  task automatic drain_outputs();
    in_valid = 1'b0;
    while (pending_tokens.size() > 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall per token, then compare on transfer
  // ---------------------------------------------------------------------------
  initial begin : sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual ev=%0d content=%02h last=%0b",
                 $time, out_data.event_res, out_data.content, out_data.last_of_run);
        errors++;
      end else begin
        want = pending_tokens.pop_front();
        tokens_seen++;
        if (want.event_res == cst_pkg::EV_DONE) streams_done++;
        if (want.event_res == cst_pkg::EV_UNTERM) unterm_seen++;
        if (out_data.event_res !== want.event_res) begin
          $display("%0t: event_res mismatch: expected %0d, actual %0d",
                   $time, want.event_res, out_data.event_res);
          errors++;
        end
        if (out_data.content !== want.content) begin
          $display("%0t: content mismatch: expected %02h, actual %02h",
                   $time, want.content, out_data.content);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                   $time, want.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Byte extremes, plain field and row ends, empty stream end
  task automatic test_plain_fields();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_text(",\n", 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
  endtask

  // Doubled quote, close by other byte, quote in unquoted field, pending quote at end
  task automatic test_quoting();
    send_text("\"a\"\"b\"c,a\"\n", 1'b0);
    send_text("\"x\"", 1'b1);
  endtask

  // CRLF as one row end, CR then other byte, trailing empty field,
  // unterminated quote, and an absent byte without end of stream
  task automatic test_line_ends();
    send_text("\015\n\015a,", 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_text("\"q", 1'b1);
    send_item(8'h41, 1'b0, 1'b1);
  endtask

  // Random streams: mostly well-formed rows, some broken and some noise
  task automatic test_random_streams(input int target);
    int         start, mode, nrec, nfld, len, n;
    logic [7:0] b;
    logic [7:0] specials[4];
    bit         quoted;
    specials[0] = cst_pkg::CH_QUOTE;
    specials[1] = cst_pkg::CH_COMMA;
    specials[2] = cst_pkg::CH_CR;
    specials[3] = cst_pkg::CH_LF;
    start = items_sent;
    n = 0;
    while (items_sent - start < target) begin
      calm = ($urandom_range(0, 4) == 0);
      mode = $urandom_range(0, 9);
      n++;
      if (mode < 8) begin
        nrec = $urandom_range(1, 3);
        for (int r = 0; r < nrec; r++) begin
          nfld = $urandom_range(1, 4);
          for (int f = 0; f < nfld; f++) begin
            if (f > 0) send_item(cst_pkg::CH_COMMA, 1'b0, 1'b0);
            quoted = ($urandom_range(0, 2) == 0);
            len = $urandom_range(0, 4);
            if (quoted) begin
              send_item(cst_pkg::CH_QUOTE, 1'b0, 1'b0);
              for (int j = 0; j < len; j++) begin
                b = ($urandom_range(0, 2) == 0) ? specials[$urandom_range(0, 3)]
                                                : 8'($urandom_range(0, 255));
                send_item(b, 1'b0, 1'b0);
                if (b == cst_pkg::CH_QUOTE) send_item(cst_pkg::CH_QUOTE, 1'b0, 1'b0);
              end
              // Leave the last quote open now and then
              if (!(mode == 7 && r == nrec - 1 && f == nfld - 1))
                send_item(cst_pkg::CH_QUOTE, 1'b0, 1'b0);
            end else begin
              for (int j = 0; j < len; j++) begin
                b = 8'($urandom_range(0, 255));
                if (b == cst_pkg::CH_QUOTE || b == cst_pkg::CH_COMMA ||
                    b == cst_pkg::CH_CR || b == cst_pkg::CH_LF)
                  b = 8'($urandom_range(8'h30, 8'h39));
                if (j > 0 && $urandom_range(0, 5) == 0) b = cst_pkg::CH_QUOTE;
                send_item(b, 1'b0, 1'b0);
              end
            end
          end
          // Row end, sometimes missing on the last row
          if (r < nrec - 1 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 2))
              0: send_item(cst_pkg::CH_CR, 1'b0, 1'b0);
              1: send_item(cst_pkg::CH_LF, 1'b0, 1'b0);
              default: begin
                send_item(cst_pkg::CH_CR, 1'b0, 1'b0);
                send_item(cst_pkg::CH_LF, 1'b0, 1'b0);
              end
            endcase
          end
        end
        // End of stream: absent byte or one last byte
        if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        if ($urandom_range(0, 2) == 0) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        else send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end else begin
        // Noise with random stream ends, then close the stream
        len = $urandom_range(5, 20);
        for (int j = 0; j < len; j++) begin
          b = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 3)]
                                          : 8'($urandom_range(0, 255));
          send_item(b, ($urandom_range(0, 19) == 0), ($urandom_range(0, 19) == 0));
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      if (n % 10 == 5) drain_outputs();
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    clear_flags();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_plain_fields();
    test_quoting();
    drain_outputs();
    test_line_ends();
    test_random_streams(400);

    // Wait out the tail, then watch for stray tokens
    drain_outputs();
    repeat (8) @(negedge clk);

    $display("Sent %0d text items over %0d streams (%0d unterminated quotes)",
             items_sent, streams_done, unterm_seen);
    $display("Checked %0d tokens under random input gaps and output stalls", tokens_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
